### design/rxf_pkg.sv
// ----------------------------------------------------------------------------
// rxf_pkg: shared types and constants for the receive filter
// Result record, parse phases, verdict and destination class codes, and the
// frame length limits used by the parser, and the result queue depth.
// ----------------------------------------------------------------------------
package rxf_pkg;

    localparam int LEN_W = 11;
    localparam logic [LEN_W-1:0] LEN_MAX          = 11'd2047;
    localparam logic [LEN_W-1:0] MAX_TAGGED_LEN   = 11'd1522;
    localparam logic [LEN_W-1:0] MAX_UNTAGGED_LEN = 11'd1514;
    localparam logic [LEN_W-1:0] HDR_BYTES        = 11'd14;
    localparam logic [LEN_W-1:0] ADDR_BYTES       = 11'd6;
    localparam logic [LEN_W-1:0] ADDR_LAST_POS    = 11'd11;
    localparam logic [1:0]       MAX_TAGS         = 2'd2;
    localparam logic [1:0]       TAGS_SAT         = 2'd3;

    localparam logic [15:0] TPID_Q   = 16'h8100;
    localparam logic [15:0] TPID_AD  = 16'h88A8;
    localparam logic [15:0] TYPE_ARP = 16'h0806;
    localparam logic [15:0] TYPE_IP4 = 16'h0800;
    localparam logic [15:0] TYPE_IP6 = 16'h86DD;

    localparam int MAC_W   = 48;
    localparam int HEN_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_ENABLE = 1'd1;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    // m_tdata width: 54 payload bits padded to whole bytes
    localparam int M_DATA_W = 56;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_TCI_HI,
        PH_TCI_LO,
        PH_PAYLOAD,
        PH_DROP
    } rxf_phase_t;

    typedef enum logic [2:0] {
        V_ARP       = 3'd0,
        V_IPV4      = 3'd1,
        V_IPV6      = 3'd2,
        V_UNHANDLED = 3'd3,
        V_RUNT      = 3'd4,
        V_TOO_LONG  = 3'd5,
        V_NOT_OURS  = 3'd6,
        V_VLAN_BAD  = 3'd7
    } rxf_verdict_t;

    typedef enum logic [1:0] {
        DC_UNICAST   = 2'd0,
        DC_MULTICAST = 2'd1,
        DC_BROADCAST = 2'd2
    } rxf_dclass_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        rxf_dclass_t      dest_class;
        logic [1:0]       tag_count;
        logic [11:0]      vlan_id;
        logic [15:0]      inner_type;
        rxf_verdict_t     verdict;
        logic             frame_end;
        logic             byte_valid;
        logic [7:0]       out_byte;
    } rxf_result_t;

endpackage

### design/eth_rx_filter_vlan_strip.sv
// ----------------------------------------------------------------------------
// eth_rx_filter_vlan_strip: receive address filter with VLAN tag stripping
// Results are registered in a four-entry result queue, which sets how far
// input runs ahead. Throughput: one byte per cycle while the queue has two
// free slots; the inner ethertype's second byte yields two transfers.
// Reset: aresetn synchronous, active low; clears parse state and queue,
// station_mac to zero and handler_enable to all handlers present.
// ----------------------------------------------------------------------------
module eth_rx_filter_vlan_strip (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,   // in_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] out_byte, [10:8] verdict, [26:11] inner_type, [38:27] vlan_id,
    // [40:39] tag_count, [42:41] dest_class, [53:43] frame_length, [55:54] 0
    output logic [rxf_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,   // frame_end
    output logic [0:0]                      m_tuser,   // [0] byte_valid
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rxf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rxf_pkg::MAC_W-1:0]       cfg_data
);
    import rxf_pkg::*;

    logic [MAC_W-1:0] mac_reg;
    logic [HEN_W-1:0] hen_reg;
    logic             in_accept;
    logic             room;
    rxf_result_t      res0, res1, head;
    logic [1:0]       res_cnt;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg <= '0;
            hen_reg <= 3'd7;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STATION_MAC:    mac_reg <= cfg_data;
                CFG_HANDLER_ENABLE: hen_reg <= cfg_data[HEN_W-1:0];
                default: ;
            endcase
        end
    end

    rxf_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .in_byte        (s_tdata),
        .in_last        (s_tlast),
        .station_mac    (mac_reg),
        .handler_enable (hen_reg),
        .res0           (res0),
        .res1           (res1),
        .res_cnt        (res_cnt)
    );

    rxf_result_q u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr0      (res0),
        .wr1      (res1),
        .wr_cnt   (res_cnt),
        .room     (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    assign m_tdata = {2'b00, head.frame_length, head.dest_class, head.tag_count,
                      head.vlan_id, head.inner_type, head.verdict, head.out_byte};
    assign m_tlast = head.frame_end;
    assign m_tuser = head.byte_valid;

endmodule

### design/rxf_parse.sv
// ----------------------------------------------------------------------------
// rxf_parse: per-byte frame parser
// Tracks position, address match, ethertype and tag state; produces up to
// two result records for each accepted byte and the verdict on the last one.
// ----------------------------------------------------------------------------
module rxf_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic [rxf_pkg::MAC_W-1:0]     station_mac,
    input  logic [rxf_pkg::HEN_W-1:0]     handler_enable,
    output rxf_pkg::rxf_result_t          res0,
    output rxf_pkg::rxf_result_t          res1,
    output logic [1:0]                    res_cnt
);
    import rxf_pkg::*;

    logic [LEN_W-1:0] pos_reg,  pos_next;
    logic             ovf_reg,  ovf_next;
    logic             match_reg, match_next;
    logic             mc_reg,   mc_next;
    logic             ones_reg, ones_next;
    logic [7:0]       type_hi_reg, type_hi_next;
    logic [11:0]      tci_reg,  tci_next;
    logic [1:0]       tags_reg, tags_next;
    logic [11:0]      vlan_reg, vlan_next;
    logic [15:0]      type_reg, type_next;
    rxf_phase_t       phase_reg, phase_next;
    logic             verr_reg, verr_next;

    logic [7:0]       mac_byte;
    logic [15:0]      type_word;
    logic             accepted;
    logic [LEN_W-1:0] stripped_len;
    rxf_verdict_t     verdict;
    rxf_dclass_t      dclass;

    always_comb begin
        case (pos_reg[2:0])
            3'd0:    mac_byte = station_mac[47:40];
            3'd1:    mac_byte = station_mac[39:32];
            3'd2:    mac_byte = station_mac[31:24];
            3'd3:    mac_byte = station_mac[23:16];
            3'd4:    mac_byte = station_mac[15:8];
            3'd5:    mac_byte = station_mac[7:0];
            default: mac_byte = 8'd0;
        endcase
    end

    assign type_word = {type_hi_reg, in_byte};

    function automatic rxf_verdict_t dispatch(input logic [15:0] t,
                                              input logic [HEN_W-1:0] hen);
        rxf_verdict_t v;
        v = V_UNHANDLED;
        if (t == TYPE_ARP && hen[0]) v = V_ARP;
        if (t == TYPE_IP4 && hen[1]) v = V_IPV4;
        if (t == TYPE_IP6 && hen[2]) v = V_IPV6;
        return v;
    endfunction

    always_comb begin
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        match_next   = match_reg;
        mc_next      = mc_reg;
        ones_next    = ones_reg;
        type_hi_next = type_hi_reg;
        tci_next     = tci_reg;
        tags_next    = tags_reg;
        vlan_next    = vlan_reg;
        type_next    = type_reg;
        phase_next   = phase_reg;
        verr_next    = verr_reg;
        res0         = '0;
        res1         = '0;
        res_cnt      = 2'd0;
        accepted     = 1'b0;
        stripped_len = '0;
        verdict      = V_UNHANDLED;
        dclass       = DC_UNICAST;

        if (in_accept) begin
            if (pos_reg == LEN_MAX) ovf_next = 1'b1;
            else                    pos_next = pos_reg + 11'd1;

            if (!ovf_next && pos_reg < ADDR_BYTES) begin
                if (pos_reg == '0) mc_next = in_byte[0];
                if (in_byte != 8'hFF) ones_next = 1'b0;
                if (in_byte != mac_byte) match_next = 1'b0;
            end

            case (phase_reg)
                PH_ADDR: begin
                    res0.out_byte   = in_byte;
                    res0.byte_valid = 1'b1;
                    res_cnt         = 2'd1;
                    if (pos_reg >= ADDR_LAST_POS) phase_next = PH_TYPE_HI;
                end
                PH_TYPE_HI: begin
                    type_hi_next = in_byte;
                    phase_next   = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    type_next = type_word;
                    if (tags_reg != 2'd0) vlan_next = tci_reg;
                    if (type_word == TPID_Q || type_word == TPID_AD) begin
                        if (tags_reg >= MAX_TAGS) begin
                            verr_next  = 1'b1;
                            phase_next = PH_DROP;
                        end else begin
                            phase_next = PH_TCI_HI;
                        end
                        if (tags_reg != TAGS_SAT) tags_next = tags_reg + 2'd1;
                    end else begin
                        // release the held ethertype as two transfers
                        res0.out_byte   = type_hi_reg;
                        res0.byte_valid = 1'b1;
                        res1.out_byte   = in_byte;
                        res1.byte_valid = 1'b1;
                        res_cnt         = 2'd2;
                        phase_next      = PH_PAYLOAD;
                    end
                end
                PH_TCI_HI: begin
                    tci_next   = {in_byte[3:0], 8'd0};
                    phase_next = PH_TCI_LO;
                end
                PH_TCI_LO: begin
                    tci_next   = {tci_reg[11:8], in_byte};
                    phase_next = PH_TYPE_HI;
                end
                PH_PAYLOAD: begin
                    res0.out_byte   = in_byte;
                    res0.byte_valid = 1'b1;
                    res_cnt         = 2'd1;
                end
                default: ;
            endcase

            if (in_last) begin
                accepted     = mc_next || (station_mac == '0) || match_next;
                stripped_len = pos_next - {7'd0, tags_next, 2'b00};
                if (pos_next < HDR_BYTES)
                    verdict = V_RUNT;
                else if (ovf_next || pos_next > MAX_TAGGED_LEN)
                    verdict = V_TOO_LONG;
                else if (!accepted)
                    verdict = V_NOT_OURS;
                else if (verr_next || phase_next != PH_PAYLOAD)
                    verdict = V_VLAN_BAD;
                else if (tags_next != 2'd0 && stripped_len > MAX_UNTAGGED_LEN)
                    verdict = V_VLAN_BAD;
                else
                    verdict = dispatch(type_next, handler_enable);

                if (mc_next)
                    dclass = (ones_next && pos_next >= ADDR_BYTES) ? DC_BROADCAST
                                                                     : DC_MULTICAST;

                // close the frame on the last result of this byte
                if (res_cnt == 2'd2) begin
                    res1.frame_end    = 1'b1;
                    res1.verdict      = verdict;
                    res1.inner_type   = type_next;
                    res1.vlan_id      = vlan_next;
                    res1.tag_count    = tags_next;
                    res1.dest_class   = dclass;
                    res1.frame_length = pos_next;
                end else begin
                    res0.frame_end    = 1'b1;
                    res0.verdict      = verdict;
                    res0.inner_type   = type_next;
                    res0.vlan_id      = vlan_next;
                    res0.tag_count    = tags_next;
                    res0.dest_class   = dclass;
                    res0.frame_length = pos_next;
                    res_cnt           = 2'd1 | res_cnt;
                end

                pos_next     = '0;
                ovf_next     = 1'b0;
                match_next   = 1'b1;
                mc_next      = 1'b0;
                ones_next    = 1'b1;
                type_hi_next = '0;
                tci_next     = '0;
                tags_next    = '0;
                vlan_next    = '0;
                type_next    = '0;
                phase_next   = PH_ADDR;
                verr_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            match_reg   <= 1'b1;
            mc_reg      <= 1'b0;
            ones_reg    <= 1'b1;
            type_hi_reg <= '0;
            tci_reg     <= '0;
            tags_reg    <= '0;
            vlan_reg    <= '0;
            type_reg    <= '0;
            phase_reg   <= PH_ADDR;
            verr_reg    <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            match_reg   <= match_next;
            mc_reg      <= mc_next;
            ones_reg    <= ones_next;
            type_hi_reg <= type_hi_next;
            tci_reg     <= tci_next;
            tags_reg    <= tags_next;
            vlan_reg    <= vlan_next;
            type_reg    <= type_next;
            phase_reg   <= phase_next;
            verr_reg    <= verr_next;
        end
    end

endmodule

### design/rxf_result_q.sv
// ----------------------------------------------------------------------------
// rxf_result_q: result queue
// Four-entry register queue that takes up to two records per cycle and
// presents one record per cycle to the output stream while it is ready.
// ----------------------------------------------------------------------------
module rxf_result_q (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rxf_pkg::rxf_result_t wr0,
    input  rxf_pkg::rxf_result_t wr1,
    input  logic [1:0]           wr_cnt,
    output logic                 room,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output rxf_pkg::rxf_result_t rd_data
);
    import rxf_pkg::*;

    rxf_result_t        entry_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wp_reg, wp_next;
    logic [RQ_AW-1:0]   rp_reg, rp_next;
    logic [RQ_AW:0]     cnt_reg, cnt_next;
    logic               pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = entry_reg[rp_reg];
    // two free slots needed: one byte can yield two transfers
    assign room     = (cnt_reg <= (RQ_AW+1)'(RQ_DEPTH - 2));

    always_comb begin
        wp_next  = wp_reg + wr_cnt;
        rp_next  = rp_reg + {{(RQ_AW-1){1'b0}}, pop};
        cnt_next = cnt_reg + {{(RQ_AW-1){1'b0}}, wr_cnt}
                           - {{RQ_AW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) entry_reg[wp_reg] <= wr0;
        if (wr_cnt == 2'd2) entry_reg[wp_reg + RQ_AW'(1)] <= wr1;
    end

endmodule

### design/rxf_checker.sv
// ----------------------------------------------------------------------------
// rxf_checker: port-level checks for the receive filter
// Watches the output stream for stalled-transfer stability and for the
// field rules of mid-frame and frame-closing results.
// ----------------------------------------------------------------------------
module rxf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rxf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast,
    input logic [0:0]                   m_tuser
);
    import rxf_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // frame fields are zero except on the closing transfer
    a_mid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[M_DATA_W-1:8] == '0)
        else $error("frame fields set before frame end");

    // a transfer without a byte only closes a frame
    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("empty transfer not closing a frame");

    a_dclass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[42:41] != 2'b11 && m_tdata[55:54] == 2'b00)
        else $error("bad destination class or padding");

    a_runt_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[10:8] == V_RUNT |-> m_tdata[53:43] < HDR_BYTES)
        else $error("runt verdict on full-size frame");

endmodule

bind eth_rx_filter_vlan_strip rxf_checker u_rxf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
